FILE: sv/ustar_archive_deframer_defines.svh
// Assertion macros for the ustar deframer.
// Expects clk and arst_n in the scope where the macros are used.
`ifndef USTAR_ARCHIVE_DEFRAMER_DEFINES_SVH
`define USTAR_ARCHIVE_DEFRAMER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define UAD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define UAD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/ustar_pkg.sv
// Shared types and constants for the ustar archive deframer.
// No dependencies; used by the parser, the result queue and the top level.
package ustar_pkg;

	localparam int SIZE_BITS = 36;
	localparam int OFF_BITS  = 9;
	localparam int AREA_BITS = SIZE_BITS + 1;

	// Header block offsets
	localparam logic [OFF_BITS-1:0] BLK_LAST   = 9'd511;
	localparam logic [OFF_BITS-1:0] NAME_LEN   = 9'd100;
	localparam logic [OFF_BITS-1:0] SIZE_FIRST = 9'd124;
	localparam logic [OFF_BITS-1:0] SIZE_LAST  = 9'd135;
	localparam logic [OFF_BITS-1:0] TYPE_OFF   = 9'd156;
	localparam logic [OFF_BITS-1:0] MAGIC_FIRST = 9'd257;
	localparam logic [OFF_BITS-1:0] MAGIC_LAST  = 9'd264;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_SEVEN = 8'h37;

	typedef enum logic [1:0] {
		KIND_NAME    = 2'd0,
		KIND_DATA    = 2'd1,
		KIND_VERDICT = 2'd2,
		KIND_DONE    = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		PH_HEADER = 3'b001,
		PH_DATA   = 3'b010,
		PH_HALT   = 3'b100
	} phase_t;

	typedef struct packed {
		kind_t                kind;
		logic [7:0]           data;
		logic                 file_last;
		logic [SIZE_BITS-1:0] size;
		logic                 is_regular;
		logic                 ok;
	} res_t;

	// One queue entry per input byte that has results: its first result, plus an optional
	// trailing done result that only needs its ok flag stored.
	typedef struct packed {
		res_t res;
		logic extra_done;
		logic done_ok;
	} qent_t;

	// "ustar  " followed by NUL
	function automatic logic [7:0] magic_byte(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = 8'h75;
			3'd1: c = 8'h73;
			3'd2: c = 8'h74;
			3'd3: c = 8'h61;
			3'd4: c = 8'h72;
			3'd5: c = 8'h20;
			3'd6: c = 8'h20;
			default: c = CH_NUL;
		endcase
		return c;
	endfunction

	function automatic res_t done_res(input logic ok);
		res_t r;
		r = '0;
		r.kind = KIND_DONE;
		r.ok = ok;
		return r;
	endfunction

endpackage

FILE: sv/ustar_parser.sv
// Per-byte header/data tracker: block offset, size/type/magic parsing, data countdown.
// Depends on ustar_pkg. Produces one queue entry per accepted byte that has results.
module ustar_parser (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  logic [7:0]      in_byte,
	input  logic            stream_end,
	output logic            ent_valid,
	output ustar_pkg::qent_t ent
);
	import ustar_pkg::*;

	logic [OFF_BITS-1:0]  off_q, off_d;
	phase_t               phase_q, phase_d;
	logic                 name_ended_q, name_ended_d;
	logic                 fname_zero_q, fname_zero_d;
	logic                 fsize_zero_q, fsize_zero_d;
	logic [SIZE_BITS-1:0] accum_q, accum_d;
	logic                 size_inval_q, size_inval_d;
	logic                 size_closed_q, size_closed_d;
	logic [7:0]           etype_q, etype_d;
	logic                 magic_ok_q, magic_ok_d;
	logic [SIZE_BITS-1:0] file_left_q, file_left_d;
	logic [AREA_BITS-1:0] area_left_q, area_left_d;
	logic                 bad_q, bad_d;

	res_t                 res0;
	logic                 have0;
	logic [SIZE_BITS-1:0] size_v;
	logic                 reg_v;
	logic [SIZE_BITS-OFF_BITS:0] blocks_v;
	logic [AREA_BITS-1:0] area_v;
	logic [OFF_BITS-1:0]  moff;

	always_comb begin
		off_d         = off_q;
		phase_d       = phase_q;
		name_ended_d  = name_ended_q;
		fname_zero_d  = fname_zero_q;
		fsize_zero_d  = fsize_zero_q;
		accum_d       = accum_q;
		size_inval_d  = size_inval_q;
		size_closed_d = size_closed_q;
		etype_d       = etype_q;
		magic_ok_d    = magic_ok_q;
		file_left_d   = file_left_q;
		area_left_d   = area_left_q;
		bad_d         = bad_q;
		res0          = '0;
		have0         = 1'b0;

		size_v   = size_inval_q ? '0 : accum_q;
		reg_v    = (etype_q == CH_NUL) || (etype_q == CH_ZERO);
		blocks_v = {1'b0, size_v[SIZE_BITS-1:OFF_BITS]}
			+ {{(SIZE_BITS-OFF_BITS){1'b0}}, |size_v[OFF_BITS-1:0]};
		area_v   = {blocks_v, {OFF_BITS{1'b0}}};
		moff     = off_q - MAGIC_FIRST;

		case (phase_q)
			PH_DATA: begin
				if (file_left_q != '0) begin
					have0          = 1'b1;
					res0.kind      = KIND_DATA;
					res0.data      = in_byte;
					res0.file_last = (file_left_q == {{(SIZE_BITS-1){1'b0}}, 1'b1});
					file_left_d    = file_left_q - 1'b1;
				end
				if (area_left_q != '0)
					area_left_d = area_left_q - 1'b1;
				// area reaching zero returns to header parsing
				if (area_left_q <= {{(AREA_BITS-1){1'b0}}, 1'b1})
					phase_d = PH_HEADER;
			end
			PH_HEADER: begin
				if (off_q < NAME_LEN) begin
					if (off_q == '0)
						fname_zero_d = (in_byte == CH_NUL);
					if (!name_ended_q) begin
						if (in_byte == CH_NUL) begin
							name_ended_d = 1'b1;
						end else begin
							have0     = 1'b1;
							res0.kind = KIND_NAME;
							res0.data = in_byte;
						end
					end
				end
				if (off_q >= SIZE_FIRST && off_q <= SIZE_LAST) begin
					if (off_q == SIZE_FIRST)
						fsize_zero_d = (in_byte == CH_NUL);
					if (!size_closed_q) begin
						if (in_byte == CH_NUL) begin
							size_closed_d = 1'b1;
						end else if (in_byte >= CH_ZERO && in_byte <= CH_SEVEN) begin
							if (accum_q[SIZE_BITS-1 -: 3] != 3'd0)
								size_inval_d = 1'b1;
							else
								accum_d = {accum_q[SIZE_BITS-4:0], in_byte[2:0]};
						end else begin
							size_inval_d = 1'b1;
						end
					end
				end
				if (off_q == TYPE_OFF)
					etype_d = in_byte;
				if (off_q >= MAGIC_FIRST && off_q <= MAGIC_LAST
						&& in_byte != magic_byte(moff[2:0]))
					magic_ok_d = 1'b0;

				if (off_q == BLK_LAST) begin
					if (fname_zero_q && fsize_zero_q && etype_q == CH_NUL) begin
						// empty header block: nothing to report
					end else if (!magic_ok_q) begin
						have0     = 1'b1;
						res0.kind = KIND_VERDICT;
						bad_d     = 1'b1;
						phase_d   = PH_HALT;
					end else begin
						have0           = 1'b1;
						res0.kind       = KIND_VERDICT;
						res0.size       = size_v;
						res0.is_regular = reg_v;
						res0.ok         = !bad_q;
						area_left_d     = area_v;
						file_left_d     = reg_v ? size_v : '0;
						phase_d         = (area_v != '0) ? PH_DATA : PH_HEADER;
					end
					off_d         = '0;
					name_ended_d  = 1'b0;
					fname_zero_d  = 1'b0;
					fsize_zero_d  = 1'b0;
					accum_d       = '0;
					size_inval_d  = 1'b0;
					size_closed_d = 1'b0;
					etype_d       = CH_NUL;
					magic_ok_d    = 1'b1;
				end else begin
					off_d = off_q + 1'b1;
				end
			end
			default: begin
				// halted: ignore bytes until the stream ends
			end
		endcase

		ent_valid = have0 || stream_end;
		if (have0) begin
			ent.res        = res0;
			ent.extra_done = stream_end;
		end else begin
			ent.res        = done_res(!bad_d);
			ent.extra_done = 1'b0;
		end
		ent.done_ok = !bad_d;

		if (stream_end) begin
			off_d         = '0;
			phase_d       = PH_HEADER;
			name_ended_d  = 1'b0;
			fname_zero_d  = 1'b0;
			fsize_zero_d  = 1'b0;
			accum_d       = '0;
			size_inval_d  = 1'b0;
			size_closed_d = 1'b0;
			etype_d       = CH_NUL;
			magic_ok_d    = 1'b1;
			file_left_d   = '0;
			area_left_d   = '0;
			bad_d         = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q         <= '0;
			phase_q       <= PH_HEADER;
			name_ended_q  <= 1'b0;
			fname_zero_q  <= 1'b0;
			fsize_zero_q  <= 1'b0;
			accum_q       <= '0;
			size_inval_q  <= 1'b0;
			size_closed_q <= 1'b0;
			etype_q       <= CH_NUL;
			magic_ok_q    <= 1'b1;
			file_left_q   <= '0;
			area_left_q   <= '0;
			bad_q         <= 1'b0;
		end else if (accept) begin
			off_q         <= off_d;
			phase_q       <= phase_d;
			name_ended_q  <= name_ended_d;
			fname_zero_q  <= fname_zero_d;
			fsize_zero_q  <= fsize_zero_d;
			accum_q       <= accum_d;
			size_inval_q  <= size_inval_d;
			size_closed_q <= size_closed_d;
			etype_q       <= etype_d;
			magic_ok_q    <= magic_ok_d;
			file_left_q   <= file_left_d;
			area_left_q   <= area_left_d;
			bad_q         <= bad_d;
		end
	end

endmodule

FILE: sv/ustar_outq.sv
// Two-entry result queue; an entry may expand into a second done transaction.
// Depends on ustar_pkg.
module ustar_outq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ustar_pkg::qent_t ent,
	output logic             room,
	output logic             out_valid,
	input  logic             out_ready,
	output ustar_pkg::res_t  out_res,
	output logic             out_last
);
	import ustar_pkg::*;

	qent_t      mem_q [2];
	logic       wptr_q, rptr_q;
	logic [1:0] cnt_q;
	logic       sub_q;
	qent_t      head;
	logic       take, pop;

	assign head      = mem_q[rptr_q];
	assign room      = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign take      = out_valid && out_ready;
	assign pop       = take && (sub_q || !head.extra_done);

	always_comb begin
		if (sub_q) begin
			out_res  = done_res(head.done_ok);
			out_last = 1'b1;
		end else begin
			out_res  = head.res;
			out_last = !head.extra_done;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wptr_q] <= ent;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
			sub_q  <= 1'b0;
		end else begin
			if (push)
				wptr_q <= !wptr_q;
			if (pop)
				rptr_q <= !rptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
			if (pop)
				sub_q <= 1'b0;
			else if (take)
				sub_q <= 1'b1;
		end
	end

endmodule

FILE: sv/ustar_archive_deframer.sv
// ustar_archive_deframer: one archive byte per cycle in while the result queue
// has room, results out on a stream. A byte's first result is registered in
// the result queue and offered on m_* from there; a byte that yields a result
// and the done result needs two transfers out of the two-entry result queue.
// Reset (arst_n low, asynchronous) returns to header parsing at block offset 0.
// Depends on ustar_pkg, ustar_parser, ustar_outq and the defines header.
`include "ustar_archive_deframer_defines.svh"
module ustar_archive_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic        s_tlast,   // stream_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [7:0] out_byte, [43:8] entry_size,
	                               // [44] is_regular, [45] archive_ok, [47:46] zero
	output logic [2:0]  m_tuser,   // [1:0] out_kind, [2] file_last
	output logic        m_tlast    // result_last
);
	import ustar_pkg::*;

	logic  accept;
	logic  ent_valid;
	qent_t ent;
	logic  room;
	res_t  ores;
	logic  olast;

	assign s_tready = room;
	assign accept   = s_tvalid && room;

	ustar_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.in_byte    (s_tdata),
		.stream_end (s_tlast),
		.ent_valid  (ent_valid),
		.ent        (ent)
	);

	ustar_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept && ent_valid),
		.ent       (ent),
		.room      (room),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (ores),
		.out_last  (olast)
	);

	assign m_tdata = {2'b00, ores.ok, ores.is_regular, ores.size, ores.data};
	assign m_tuser = {ores.file_last, ores.kind};
	assign m_tlast = olast;

	`UAD_ASSERT_NOW(a_done_is_last, m_tvalid && m_tuser[1:0] == KIND_DONE, m_tlast,
		"done result not marked last")
	`UAD_ASSERT_NOW(a_file_last_data, m_tvalid && m_tuser[2], m_tuser[1:0] == KIND_DATA,
		"file_last on a non-data result")
	`UAD_ASSERT_NOW(a_bytes_clean,
		m_tvalid && (m_tuser[1:0] == KIND_NAME || m_tuser[1:0] == KIND_DATA),
		m_tdata[45:8] == '0, "byte result carries verdict fields")
	`UAD_ASSERT_NEXT(a_full_blocks, !room, !(accept && ent_valid) || room,
		"push into a full result queue")

endmodule
